FILE: hw/rtl/sorted_timer_queue_top_macros.svh
// assertion macros used by the sorted timer queue checker
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define STQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_timer_queue: same-cycle check failed");

// next-cycle implication, disabled during reset
`define STQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_timer_queue: next-cycle check failed");

`endif

FILE: hw/rtl/stq_pkg.sv
// types and constants of the sorted timer queue
package stq_pkg;

  localparam int EXP_W        = 64;
  localparam int HANDLE_W     = 16;
  localparam int DELAY_W      = 16;
  localparam int RATE_W       = 32;
  localparam int RESULT_LIMIT = 16;
  localparam int POP_W        = 5;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd3686400;

  localparam logic FUNC_ADD = 1'b0;

  typedef enum logic [1:0] {
    KIND_ADDED    = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [EXP_W-1:0]    expiry;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   shift;
    entry_t fresh;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/stq_if.sv
// channel interfaces of the sorted timer queue

interface stq_cfg_if;
  import stq_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stq_req_if;
  import stq_pkg::*;
  logic                func;
  logic [EXP_W-1:0]    now_ticks;
  logic [DELAY_W-1:0]  delay_seconds;
  logic [HANDLE_W-1:0] handle;
  logic                valid;
  logic                ready;
  modport source (output valid, output func, output now_ticks, output delay_seconds,
                  output handle, input ready);
  modport sink (input valid, input func, input now_ticks, input delay_seconds,
                input handle, output ready);
endinterface

interface stq_rsp_if;
  import stq_pkg::*;
  kind_t               kind;
  logic [HANDLE_W-1:0] expired_handle;
  logic                last;
  logic                valid;
  logic                ready;
  modport source (output valid, output kind, output expired_handle, output last,
                  input ready);
  modport sink (input valid, input kind, input expired_handle, input last,
                output ready);
endinterface

FILE: hw/rtl/stq_div.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor
module stq_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [stq_pkg::EXP_W-1:0]      dividend,
  input  logic [stq_pkg::RATE_W-1:0]     divisor,
  output logic                           done,
  output logic [stq_pkg::EXP_W-1:0]      quotient
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(EXP_W);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t             state;
  logic [CNT_W-1:0]    cnt;
  logic [EXP_W-1:0]    quo;
  logic [RATE_W-1:0]   rem;
  logic [RATE_W-1:0]   dvs;
  logic [RATE_W:0]     shifted;
  logic [RATE_W:0]     trial;
  logic                qbit;
  logic [RATE_W-1:0]   rem_next;

  always_comb begin
    shifted  = {rem, quo[EXP_W-1]};
    trial    = shifted - {1'b0, dvs};
    qbit     = (shifted >= {1'b0, dvs});
    rem_next = qbit ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= dividend;
            rem   <= '0;
            dvs   <= divisor;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= rem_next;
          quo <= {quo[EXP_W-2:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(EXP_W - 1)) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/stq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward head or tail
module stq_cell (
  input  logic               clk,
  input  stq_pkg::cell_cmd_t cmd,
  input  logic               occ,
  input  logic               prev_occ,
  input  logic               prev_after,
  input  stq_pkg::entry_t    prev_entry,
  input  stq_pkg::entry_t    next_entry,
  input  logic [stq_pkg::EXP_W-1:0] uptime,
  output logic               after,
  output logic               due,
  output stq_pkg::entry_t    entry
);
  import stq_pkg::*;

  // equal expiries stay ahead of the new entry
  assign after = occ && (entry.expiry > cmd.fresh.expiry);
  assign due   = (entry.expiry <= uptime);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (prev_after) begin
        entry <= prev_entry;
      end else if (prev_occ && (after || !occ)) begin
        entry <= cmd.fresh;
      end
    end else if (cmd.shift) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: hw/rtl/sorted_timer_queue_top.sv
// Sorted timer queue, top level.
// Channels: cfg writes ticks_per_second (always ready; the user must write it
// only while idle, which the block does not enforce), req carries one item
// (func, now_ticks, delay_seconds, handle), rsp returns results (kind,
// expired_handle, last) through an output register.
// Every item first divides now_ticks by ticks_per_second (0 acts as 1) in a
// bit-serial divider. An add then forms the saturating expiry sum (S_EXP) and
// does a sorted insert into the cell chain (S_INSERT), giving its one result.
// A tick pops one due head entry per cycle as long as rsp keeps up, up to 16,
// the last result flagged; a tick with nothing due gives no result and frees
// the block after its division. req is accepted only when the previous item
// has produced all its results, after the divider loop and insert or pop walk.
// A stalled rsp holds the result and stalls the insert or pop walk; the next
// req may be taken while the last result still waits in the output register.
// Reset (synchronous) empties the queue and loads ticks_per_second = 3686400.
module sorted_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  stq_cfg_if.sink   cfg,
  stq_req_if.sink   req,
  stq_rsp_if.source rsp
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EXP, S_INSERT, S_POP} state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [RATE_W-1:0]   rate;
  logic [RATE_W-1:0]   rate_eff;
  logic                func_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [EXP_W-1:0]    uptime;
  logic [EXP_W-1:0]    exp_new;
  logic [EXP_W:0]      exp_sum;
  logic [POP_W-1:0]    pop_n;
  logic                out_valid;
  kind_t               out_kind;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_last;

  logic                start;
  logic                div_done;
  logic [EXP_W-1:0]    quotient;
  logic                out_free;
  logic                full;
  logic                head_due;
  logic                pop_last;
  cell_cmd_t           cmd;

  entry_t              entries     [QUEUE_DEPTH];
  entry_t              prev_entry_v[QUEUE_DEPTH];
  entry_t              next_entry_v[QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ_v;
  logic [QUEUE_DEPTH-1:0] prev_occ_v;
  logic [QUEUE_DEPTH-1:0] prev_after_v;
  logic [QUEUE_DEPTH-1:0] after_v;
  logic [QUEUE_DEPTH-1:0] due_v;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign start     = req.valid && req.ready;
  assign rate_eff  = (rate == '0) ? RATE_W'(1) : rate;

  stq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (req.now_ticks),
    .divisor  (rate_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // neighbor wiring of the chain; head and tail ends tie to themselves
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ_v[i] = (CNT_W'(i) < count);
      if (i == 0) begin
        prev_occ_v[i]   = 1'b1;
        prev_after_v[i] = 1'b0;
        prev_entry_v[i] = entries[i];
      end else begin
        prev_occ_v[i]   = occ_v[i-1];
        prev_after_v[i] = after_v[i-1];
        prev_entry_v[i] = entries[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin
        next_entry_v[i] = entries[i];
      end else begin
        next_entry_v[i] = entries[i+1];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      stq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ_v[g]),
        .prev_occ   (prev_occ_v[g]),
        .prev_after (prev_after_v[g]),
        .prev_entry (prev_entry_v[g]),
        .next_entry (next_entry_v[g]),
        .uptime     (uptime),
        .after      (after_v[g]),
        .due        (due_v[g]),
        .entry      (entries[g])
      );
    end
  endgenerate

  assign out_free = !out_valid || rsp.ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign head_due = occ_v[0] && due_v[0];
  assign pop_last = !(occ_v[1] && due_v[1]) || (pop_n == POP_W'(RESULT_LIMIT - 1));
  assign exp_sum  = {1'b0, uptime} + (EXP_W + 1)'(delay_q);

  always_comb begin
    cmd.insert       = (state == S_INSERT) && out_free && !full;
    cmd.shift        = (state == S_POP) && out_free && head_due;
    cmd.fresh.expiry = exp_new;
    cmd.fresh.handle = handle_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rate      <= RATE_RESET;
    end else begin
      if (cfg.valid) begin
        rate <= cfg.data;
      end
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q   <= req.func;
            delay_q  <= req.delay_seconds;
            handle_q <= req.handle;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            uptime <= quotient;
            pop_n  <= '0;
            state  <= (func_q == FUNC_ADD) ? S_EXP : S_POP;
          end
        end
        S_EXP: begin
          // saturate on carry out
          exp_new <= exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];
          state   <= S_INSERT;
        end
        S_INSERT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= full ? KIND_REJECTED : KIND_ADDED;
            out_handle <= handle_q;
            out_last   <= 1'b1;
            if (!full) begin
              count <= count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_POP: begin
          if (out_free) begin
            if (head_due) begin
              out_valid  <= 1'b1;
              out_kind   <= KIND_EXPIRED;
              out_handle <= entries[0].handle;
              out_last   <= pop_last;
              count      <= count - 1'b1;
              pop_n      <= pop_n + 1'b1;
              if (pop_last) begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.kind           = out_kind;
  assign rsp.expired_handle = out_handle;
  assign rsp.last           = out_last;

endmodule

FILE: hw/rtl/stq_check.sv
// port-level checker of the sorted timer queue and its bind
`include "sorted_timer_queue_top_macros.svh"

module stq_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input stq_pkg::kind_t               rsp_kind,
  input logic [stq_pkg::HANDLE_W-1:0] rsp_expired_handle,
  input logic                         rsp_last
);
  import stq_pkg::*;

  // a held result keeps its payload
  `STQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_kind) && $stable(rsp_expired_handle) && $stable(rsp_last))

  // the block is busy right after taking an item
  `STQ_ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)

  // add status is always the only result of its item
  `STQ_ASSERT_IMPLY(a_status_last, clk, rst,
    rsp_valid && (rsp_kind == KIND_ADDED || rsp_kind == KIND_REJECTED), rsp_last)

  // ready for an item once reset is released
  `STQ_ASSERT_IMPLY(a_ready_after_rst, clk, rst, $fell(rst), req_ready)

endmodule

bind sorted_timer_queue_top stq_check u_stq_check (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_kind           (rsp.kind),
  .rsp_expired_handle (rsp.expired_handle),
  .rsp_last           (rsp.last)
);

FILE: test/tb_sorted_timer_queue_top.sv
// self-checking testbench of the sorted timer queue top level
module tb_sorted_timer_queue_top;
  import stq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int SETTLE_CYCLES = 90;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int PHASE_ITEMS   = 52;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic [EXP_W-1:0] NOW_MAX = '1;

  typedef enum int {
    PRESSURE_NONE,
    PRESSURE_HOLD,
    PRESSURE_PAUSE
  } pressure_t;

  typedef struct {
    logic                func;
    logic [EXP_W-1:0]    now_ticks;
    logic [DELAY_W-1:0]  delay_seconds;
    logic [HANDLE_W-1:0] handle;
  } timer_req_t;

  typedef struct {
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } timer_rsp_t;

  logic clk = 1'b0;
  logic rst;

  stq_cfg_if cfg ();
  stq_req_if req ();
  stq_rsp_if rsp ();

  sorted_timer_queue_top #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp)
  );

  timer_req_t        request_backlog[$];
  timer_req_t        offered;
  timer_rsp_t        pending_results[$];
  entry_t            shadow_timers[$];
  logic [RATE_W-1:0] shadow_rate    = RATE_RESET;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_seq       = 0;
  int                hold_seen;
  int                stall_left;
  int                errors         = 0;
  int                cycles         = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // queue model: applies one accepted request and records the results it owes
  function automatic void advance_timers(timer_req_t it);
    logic [EXP_W-1:0] uptime;
    logic [EXP_W:0]   sum;
    entry_t           fresh;
    timer_rsp_t       r;
    int               pos;
    int               popped;
    uptime = it.now_ticks / ((shadow_rate == '0) ? 64'd1 : 64'(shadow_rate));
    r.handle = it.handle;
    r.last = 1'b1;
    if (it.func == FUNC_ADD) begin
      if (shadow_timers.size() >= DEPTH) begin
        r.kind = KIND_REJECTED;
      end else begin
        sum = {1'b0, uptime} + it.delay_seconds;
        fresh.expiry = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
        fresh.handle = it.handle;
        // equal expiries stay in arrival order
        pos = 0;
        while (pos < shadow_timers.size() && shadow_timers[pos].expiry <= fresh.expiry) pos++;
        shadow_timers.insert(pos, fresh);
        r.kind = KIND_ADDED;
      end
      pending_results.push_back(r);
    end else begin
      popped = 0;
      while (popped < RESULT_LIMIT && shadow_timers.size() != 0 &&
             shadow_timers[0].expiry <= uptime) begin
        r.kind = KIND_EXPIRED;
        r.handle = shadow_timers[0].handle;
        r.last = 1'b0;
        void'(shadow_timers.pop_front());
        pending_results.push_back(r);
        popped++;
      end
      if (popped != 0) pending_results[pending_results.size()-1].last = 1'b1;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        advance_timers(offered);
      end
      if (!req.valid || req.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_backlog.pop_front();
          req.func <= offered.func;
          req.now_ticks <= offered.now_ticks;
          req.delay_seconds <= offered.delay_seconds;
          req.handle <= offered.handle;
          req.valid <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      stall_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : watch_results
    timer_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: kind %0d handle %h last %b",
                 $time, rsp.kind, rsp.expired_handle, rsp.last);
      end else begin
        want = pending_results.pop_front();
        if (rsp.kind !== want.kind || rsp.expired_handle !== want.handle ||
            rsp.last !== want.last) begin
          errors++;
          $display("%0t: mismatch: expected kind %0d handle %h last %b, got kind %0d handle %h last %b",
                   $time, want.kind, want.handle, want.last,
                   rsp.kind, rsp.expired_handle, rsp.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** sorted_timer_queue_top: FAILED **");
      $finish;
    end
  end

  task automatic queue_request(logic func, logic [EXP_W-1:0] now_ticks,
                               logic [DELAY_W-1:0] delay_seconds,
                               logic [HANDLE_W-1:0] handle);
    timer_req_t it;
    it.func = func;
    it.now_ticks = now_ticks;
    it.delay_seconds = delay_seconds;
    it.handle = handle;
    request_backlog.push_back(it);
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || req.valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // a tick with nothing due leaves the block busy without any result
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    shadow_rate = value;
  endtask

  // mostly coherent traffic on a running clock, with bursts and random noise
  task automatic build_traffic(int count);
    logic [EXP_W-1:0] rate;
    logic [EXP_W-1:0] seconds;
    logic [EXP_W-1:0] stamp;
    int               roll;
    rate = (shadow_rate == '0) ? 64'd1 : 64'(shadow_rate);
    seconds = 64'($urandom_range(1000));
    repeat (count) begin
      roll = $urandom_range(99);
      stamp = seconds * rate + 64'($urandom_range(32'(rate - 1)));
      if (roll < 55) begin
        queue_request(FUNC_ADD, stamp,
                      ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                      16'($urandom));
      end else if (roll < 85) begin
        seconds = seconds + 64'($urandom_range(3));
        queue_request(FUNC_TICK, seconds * rate, 16'($urandom), 16'($urandom));
      end else if (roll < 90) begin
        repeat (6) queue_request(FUNC_ADD, stamp, 16'($urandom_range(30)), 16'($urandom));
      end else begin
        queue_request(1'($urandom), {$urandom, $urandom}, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic [RATE_W-1:0] rate, int send_pct, int recv_pct,
                           pressure_t mode);
    settle();
    write_rate(rate);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (mode == PRESSURE_PAUSE) begin
      build_traffic(PHASE_ITEMS / 2);
      wait_drained();
      build_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
    end else begin
      build_traffic(PHASE_ITEMS);
      if (mode == PRESSURE_HOLD) begin
        @(posedge clk);
        hold_seq <= hold_seq + 1;
      end
    end
    // sweep out whatever has come due
    queue_request(FUNC_TICK, NOW_MAX, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.func = FUNC_ADD;
    req.now_ticks = '0;
    req.delay_seconds = '0;
    req.handle = '0;
    rsp.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset rate: empty tick, equal expiries, full queue, all entries due at once
    queue_request(FUNC_TICK, '0, '0, '0);
    queue_request(FUNC_ADD, '0, 16'd0, 16'h0000);
    queue_request(FUNC_ADD, 64'(RATE_RESET) * 5, 16'd3, 16'hffff);
    queue_request(FUNC_ADD, 64'(RATE_RESET) - 1, 16'd8, 16'h1234);
    queue_request(FUNC_TICK, 64'(RATE_RESET) * 8, '0, '0);
    repeat (DEPTH + 1)
      queue_request(FUNC_ADD, 64'(RATE_RESET) * 10, 16'($urandom_range(15)), 16'($urandom));
    queue_request(FUNC_TICK, NOW_MAX, '0, '0);

    // zero rate acts as one; expiry saturates at the top of the range
    settle();
    write_rate('0);
    queue_request(FUNC_ADD, NOW_MAX, 16'hffff, 16'haaaa);
    queue_request(FUNC_TICK, NOW_MAX - 1, '0, '0);
    queue_request(FUNC_TICK, NOW_MAX, '0, '0);

    run_phase(32'd1, 0, 0, PRESSURE_NONE);
    run_phase('1, 45, 0, PRESSURE_NONE);
    run_phase(32'd1000, 0, 45, PRESSURE_HOLD);
    run_phase(32'($urandom_range(100000, 2)), 24, 24, PRESSURE_PAUSE);
    run_phase(RATE_RESET, 0, 0, PRESSURE_NONE);

    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** sorted_timer_queue_top: PASSED **");
    end else begin
      $display("** sorted_timer_queue_top: FAILED **");
    end
    $finish;
  end

endmodule
